// ===== rtl/rmfc_pkg.sv =====
// rmfc_pkg: shared widths, frame layout constants, register indexes and types
// for the frame checker; no dependencies, compiled first
`timescale 1ns / 1ps
`default_nettype none

package rmfc_pkg;

   // default payload capacity handed to the top level
   localparam int DEFAULT_MAX_PAYLOAD = 32;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 6;
   localparam int INDEX_W    = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   // frame layout: five lead bytes, direction, command, length, payload
   localparam int LEAD_LEN      = 5;
   localparam int POS_DIRECTION = 5;
   localparam int POS_COMMAND   = 6;
   localparam int POS_LENGTH    = 7;
   localparam int HDR_LEN       = 8;

   localparam logic [BYTE_W-1:0] LEAD_MARK  = 8'hAF;
   localparam logic [BYTE_W-1:0] LEAD_ZERO  = 8'h00;
   localparam logic [BYTE_W-1:0] TRAILER_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] TRAILER_LF = 8'h0A;

   // register reset values
   localparam logic [BYTE_W-1:0] CMD_RESET = 8'd2;
   localparam logic [LEN_W-1:0]  LEN_RESET = 6'd14;
   localparam logic [BYTE_W-1:0] DIR_RESET = 8'd0;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_EXPECTED_COMMAND = 2'd0,
      CSR_EXPECTED_LENGTH  = 2'd1,
      CSR_DIRECTION_BYTE   = 2'd2
   } csr_index_type;

   // kind of result item
   typedef enum logic {
      RESULT_PAYLOAD = 1'b0,
      RESULT_VERDICT = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] expected_command;
      logic [LEN_W-1:0]  expected_length;
      logic [BYTE_W-1:0] direction_byte;
   } cfg_type;

   typedef struct packed {
      result_kind_type    result_kind;
      logic [BYTE_W-1:0]  payload_byte;
      logic [INDEX_W-1:0] payload_index;
      logic               frame_error;
   } rsp_type;

   // expected lead byte at offsets zero to four
   function automatic logic [BYTE_W-1:0] lead_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] val;
      unique case (idx)
         3'd0, 3'd1, 3'd4: val = LEAD_MARK;
         default:          val = LEAD_ZERO;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rmfc_channels.sv =====
// rmfc_req_if and rmfc_rsp_if: valid/ready channels for received bytes and
// results; widths from rmfc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rmfc_req_if;
   logic                         valid;
   logic                         ready;
   logic [rmfc_pkg::BYTE_W-1:0]  rx_byte;
   logic                         frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface rmfc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         result_kind;
   logic [rmfc_pkg::BYTE_W-1:0]  payload_byte;
   logic [rmfc_pkg::INDEX_W-1:0] payload_index;
   logic                         frame_error;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output frame_error, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input frame_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/rmfc_csr.sv =====
// rmfc_csr: expected command, length and direction registers behind a plain
// write port; uses rmfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmfc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [rmfc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [rmfc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rmfc_pkg::cfg_type                    cfg
);
   import rmfc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // decode the write; unknown indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EXPECTED_COMMAND: cfg_in.expected_command = BYTE_W'(csr_wdata);
            CSR_EXPECTED_LENGTH:  cfg_in.expected_length  = LEN_W'(csr_wdata);
            CSR_DIRECTION_BYTE:   cfg_in.direction_byte   = BYTE_W'(csr_wdata);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= CMD_RESET;
         cfg_ff.expected_length  <= LEN_RESET;
         cfg_ff.direction_byte   <= DIR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/rmfc_check.sv =====
// rmfc_check: byte position counter, running checksum and mismatch flag,
// plus the per-byte compare that forms the result; uses rmfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmfc_check #(
   parameter int MAX_PAYLOAD = rmfc_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [rmfc_pkg::BYTE_W-1:0] rx_byte,
   input  wire logic                        frame_start,
   input  wire rmfc_pkg::cfg_type           cfg,
   output logic                             res_valid,
   output rmfc_pkg::rsp_type                res
);
   import rmfc_pkg::*;

   // position runs up to one past the final trailer byte
   localparam int POS_W = $clog2(MAX_PAYLOAD + HDR_LEN + 4);
   localparam int MAX_W = $clog2(MAX_PAYLOAD + 1);
   localparam int SAT_W = (MAX_W > LEN_W) ? MAX_W : LEN_W;
   localparam int CMP_W = (SAT_W > BYTE_W) ? SAT_W : BYTE_W;

   logic [POS_W-1:0]  pos_ff, pos_in, pos_cur, cs_pos, idx_full;
   logic [BYTE_W-1:0] sum_ff, sum_in, sum_cur;
   logic              mis_ff, mis_in, mis_cur;
   logic              byte_bad, active;
   logic [SAT_W-1:0]  len_sat;

   // payload length saturated at capacity, and checksum offset
   always_comb begin
      len_sat = (SAT_W'(cfg.expected_length) > SAT_W'(MAX_PAYLOAD)) ?
                SAT_W'(MAX_PAYLOAD) : SAT_W'(cfg.expected_length);
      cs_pos  = POS_W'(HDR_LEN) + POS_W'(len_sat);
   end

   // frame start restarts the state before the byte is checked
   always_comb begin
      pos_cur  = frame_start ? '0 : pos_ff;
      sum_cur  = frame_start ? '0 : sum_ff;
      mis_cur  = frame_start ? 1'b0 : mis_ff;
      active   = (pos_cur <= cs_pos + POS_W'(2));
      idx_full = pos_cur - POS_W'(HDR_LEN);
   end

   // compare the byte against what its offset requires
   always_comb begin
      byte_bad          = 1'b0;
      res_valid         = 1'b0;
      res.result_kind   = RESULT_PAYLOAD;
      res.payload_byte  = rx_byte;
      res.payload_index = INDEX_W'(idx_full);
      res.frame_error   = 1'b0;
      priority if (pos_cur < POS_W'(LEAD_LEN)) begin
         byte_bad = (rx_byte != lead_byte(pos_cur[2:0]));
      end else if (pos_cur == POS_W'(POS_DIRECTION)) begin
         byte_bad = (rx_byte != cfg.direction_byte);
      end else if (pos_cur == POS_W'(POS_COMMAND)) begin
         byte_bad = (rx_byte != cfg.expected_command);
      end else if (pos_cur == POS_W'(POS_LENGTH)) begin
         byte_bad = (CMP_W'(rx_byte) != CMP_W'(len_sat));
      end else if (pos_cur < cs_pos) begin
         res_valid = accept;
      end else if (pos_cur == cs_pos) begin
         byte_bad = (rx_byte != sum_cur);
      end else if (pos_cur == cs_pos + POS_W'(1)) begin
         byte_bad = (rx_byte != TRAILER_CR);
      end else if (pos_cur == cs_pos + POS_W'(2)) begin
         byte_bad          = (rx_byte != TRAILER_LF);
         res_valid         = accept;
         res.result_kind   = RESULT_VERDICT;
         res.payload_byte  = '0;
         res.payload_index = '0;
         res.frame_error   = mis_cur | byte_bad;
      end else begin
         // past the trailer: nothing to check until the next frame start
         byte_bad = 1'b0;
      end
   end

   // next state: checksum covers every byte before its own offset
   always_comb begin
      pos_in = pos_cur + POS_W'(1);
      sum_in = (pos_cur < cs_pos) ? sum_cur + rx_byte : sum_cur;
      mis_in = mis_cur | byte_bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         mis_ff <= 1'b0;
      end else if (accept && active) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         mis_ff <= mis_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rmfc_out_stage.sv =====
// rmfc_out_stage: result register that drives the response channel and
// tells the input side when a new byte may be taken; uses rmfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmfc_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              res_valid,
   input  wire rmfc_pkg::rsp_type res,
   output logic                   take_ok,
   rmfc_rsp_if.source             rsp_chan
);
   import rmfc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // room when empty or when the held result leaves this cycle
   assign take_ok = !valid_ff || rsp_chan.ready;

   always_comb begin
      priority if (accept) begin
         valid_in = res_valid;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      data_in = (accept && res_valid) ? res : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // response channel
   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.result_kind   = data_ff.result_kind;
   assign rsp_chan.payload_byte  = data_ff.payload_byte;
   assign rsp_chan.payload_index = data_ff.payload_index;
   assign rsp_chan.frame_error   = data_ff.frame_error;

endmodule

`default_nettype wire

// ===== rtl/radio_module_frame_checker.sv =====
// radio_module_frame_checker: top level of the frame checker
// depends on rmfc_pkg, rmfc_channels, rmfc_csr, rmfc_check, rmfc_out_stage
//
// Usage:
//   req_chan carries one received byte per transfer with a frame_start flag
//   that makes that byte offset zero of a new frame. rsp_chan carries at most
//   one result per byte: a payload byte with its payload index, or, on the
//   final trailer byte, a verdict with frame_error set if any lead, direction,
//   command, length, checksum or trailer byte mismatched.
//   csr_we/csr_index/csr_wdata write expected command, expected length and
//   direction byte; write only while no frame is in flight.
// Timing:
//   a result shows on rsp_chan in the cycle after its byte is taken. One byte
//   per cycle is sustained while the receiver keeps up; the loop that sets it
//   is the position counter and 8-bit checksum adder, each closed through its own register.
//   When the receiver stalls, the held result stays put and req_chan.ready
//   drops only while that result is still waiting; bytes that cause no result
//   still need that slot to be free.
// Reset:
//   synchronous, active high; clears position, checksum, mismatch flag and
//   the output slot, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module radio_module_frame_checker #(
   parameter int MAX_PAYLOAD = rmfc_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rmfc_req_if.sink                             req_chan,
   rmfc_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [rmfc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [rmfc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rmfc_pkg::*;

   cfg_type cfg;
   rsp_type res;
   logic    res_valid;
   logic    take_ok;
   logic    accept;

   // input transfer
   assign req_chan.ready = take_ok;
   assign accept         = req_chan.valid && take_ok;

   // configuration registers
   rmfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // per-byte check and frame state
   rmfc_check #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_chan.rx_byte),
      .frame_start (req_chan.frame_start),
      .cfg         (cfg),
      .res_valid   (res_valid),
      .res         (res)
   );

   // result register
   rmfc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .res_valid (res_valid),
      .res       (res),
      .take_ok   (take_ok),
      .rsp_chan  (rsp_chan)
   );

   // checks
   a_ready_only_on_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("input stalled without a waiting result");

   a_start_byte_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.frame_start) |-> !res_valid)
      else $error("offset zero of a frame produced a result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid) |=> rsp_chan.valid)
      else $error("result of a taken byte did not reach the output");

endmodule

`default_nettype wire
